// ===== rtl/core/mexp_pkg.sv =====
`default_nettype none

package mexp_pkg;

    // Width of the signed base field and of the shared remainder unit's dividend
    localparam int BASE_WIDTH = 64;
    // Step counter: holds up to BASE_WIDTH
    localparam int CNT_WIDTH  = 7;
    // Modulus after reset
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,      // capture base magnitude, sign, exponent; init accumulator
        DP_DIV_STEP,  // one restoring remainder step
        DP_FIX_BASE,  // square <= canonical residue of the base
        DP_MUL_ACC,   // dividend <= acc * sq
        DP_MUL_SQ,    // dividend <= sq * sq
        DP_WB_ACC,    // acc <= remainder
        DP_WB_SQ      // sq <= remainder, exponent >>= 1
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_zero;
        logic div_last;
        logic exp_zero;
        logic exp_lsb;
        logic exp_upper_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/core/mexp_datapath.sv =====
`default_nettype none

module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = 31,
    parameter int EXP_WIDTH = 31
) (
    input  wire logic                  i_clk,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [MOD_WIDTH-1:0]  i_modulus,
    input  wire logic [BASE_WIDTH-1:0] i_base,
    input  wire logic [EXP_WIDTH-1:0]  i_exponent,
    output t_dp_stat                   o_stat,
    output logic [MOD_WIDTH-1:0]       o_result
);

    localparam int PROD_WIDTH = 2 * MOD_WIDTH;
    localparam int PROD_SHIFT = BASE_WIDTH - PROD_WIDTH;
    localparam logic [CNT_WIDTH-1:0] BASE_STEPS = CNT_WIDTH'(BASE_WIDTH);
    localparam logic [CNT_WIDTH-1:0] PROD_STEPS = CNT_WIDTH'(PROD_WIDTH);

    logic [BASE_WIDTH-1:0] r_div;
    logic [MOD_WIDTH-1:0]  r_rem;
    logic [CNT_WIDTH-1:0]  r_cnt;
    logic [MOD_WIDTH-1:0]  r_acc;
    logic [MOD_WIDTH-1:0]  r_sq;
    logic [EXP_WIDTH-1:0]  r_exp;
    logic                  r_neg;

    logic [MOD_WIDTH:0]    trial;
    logic [MOD_WIDTH:0]    trial_sub;
    logic [MOD_WIDTH-1:0]  rem_next;
    logic [MOD_WIDTH-1:0]  mul_a;
    logic [PROD_WIDTH-1:0] prod;
    logic [BASE_WIDTH-1:0] base_mag;
    logic [MOD_WIDTH-1:0]  base_res;
    logic [MOD_WIDTH-1:0]  acc_init;

    // restoring remainder step: remainder stays below the modulus
    assign trial     = {r_rem, r_div[BASE_WIDTH-1]};
    assign trial_sub = trial - {1'b0, i_modulus};
    assign rem_next  = (trial >= {1'b0, i_modulus}) ? trial_sub[MOD_WIDTH-1:0]
                                                    : trial[MOD_WIDTH-1:0];

    assign mul_a = (i_cmd.op == DP_MUL_ACC) ? r_acc : r_sq;
    assign prod  = PROD_WIDTH'(mul_a) * PROD_WIDTH'(r_sq);

    assign base_mag = i_base[BASE_WIDTH-1] ? (BASE_WIDTH'(0) - i_base) : i_base;
    // negative base: residue of the magnitude, folded to m - r
    assign base_res = (r_neg && (r_rem != '0)) ? (i_modulus - r_rem) : r_rem;
    assign acc_init = (i_modulus > MOD_WIDTH'(1)) ? MOD_WIDTH'(1) : '0;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op) inside
            DP_LOAD: begin
                r_div <= base_mag;
                r_neg <= i_base[BASE_WIDTH-1];
                r_exp <= i_exponent;
                r_rem <= '0;
                r_cnt <= BASE_STEPS;
                r_acc <= acc_init;
            end
            DP_DIV_STEP: begin
                r_rem <= rem_next;
                r_div <= r_div << 1;
                r_cnt <= r_cnt - CNT_WIDTH'(1);
            end
            DP_FIX_BASE: begin
                r_sq <= base_res;
            end
            DP_MUL_ACC, DP_MUL_SQ: begin
                r_div <= BASE_WIDTH'(prod) << PROD_SHIFT;
                r_rem <= '0;
                r_cnt <= PROD_STEPS;
            end
            DP_WB_ACC: begin
                r_acc <= r_rem;
            end
            DP_WB_SQ: begin
                r_sq  <= r_rem;
                r_exp <= r_exp >> 1;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.mod_zero       = (i_modulus == '0);
    assign o_stat.div_last       = (r_cnt == CNT_WIDTH'(1));
    assign o_stat.exp_zero       = (r_exp == '0);
    assign o_stat.exp_lsb        = r_exp[0];
    assign o_stat.exp_upper_zero = ((r_exp >> 1) == '0);
    assign o_result              = r_acc;

endmodule

`default_nettype wire

// ===== rtl/core/mexp_ctrl.sv =====
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_free,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_in_ready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_BASE,
        S_FIX,
        S_CHECK,
        S_MUL_ACC,
        S_DIV_ACC,
        S_WB_ACC,
        S_MUL_SQ,
        S_DIV_SQ,
        S_WB_SQ,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = DP_NOP;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = i_stat.mod_zero ? S_DONE : S_RED_BASE;
                end
            end
            S_RED_BASE: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_stat.div_last) n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.op = DP_FIX_BASE;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.exp_zero)     n_state = S_DONE;
                else if (i_stat.exp_lsb) n_state = S_MUL_ACC;
                else                     n_state = S_MUL_SQ;
            end
            S_MUL_ACC: begin
                o_cmd.op = DP_MUL_ACC;
                n_state  = S_DIV_ACC;
            end
            S_DIV_ACC: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_stat.div_last) n_state = S_WB_ACC;
            end
            S_WB_ACC: begin
                o_cmd.op = DP_WB_ACC;
                // top bit done: the last square is never used
                n_state  = i_stat.exp_upper_zero ? S_DONE : S_MUL_SQ;
            end
            S_MUL_SQ: begin
                o_cmd.op = DP_MUL_SQ;
                n_state  = S_DIV_SQ;
            end
            S_DIV_SQ: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_stat.div_last) n_state = S_WB_SQ;
            end
            S_WB_SQ: begin
                o_cmd.op = DP_WB_SQ;
                n_state  = S_CHECK;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation.sv =====
`default_nettype none

// Modular exponentiation: power = base ** exponent mod modulus.
// Input channel (i_in_valid / o_in_ready) carries a signed 64-bit base and an
// unsigned exponent; output channel (o_out_valid / i_out_ready) returns one
// canonical residue 0..modulus-1 per input transaction. A modulus of zero
// gives 0, an exponent of zero gives 1 mod modulus.
// Config channel (i_cfg_valid / o_cfg_ready) writes the modulus; always ready,
// write it only while no transaction is in flight. Reset sets 1000000007.
// One item at a time. From accept to o_out_valid, with W = MOD_WIDTH and b =
// index of the exponent's top set bit, the block reduces the base (64 one-bit
// remainder steps and the fold), scans b+1 exponent bits (one for a zero
// exponent), and for every set bit and for each of the b squarings runs a
// multiply, 2W remainder steps and a write-back; then it queues the result.
// A zero modulus goes straight to queuing the result. All products and the
// base go through the single shared bit-serial remainder unit.
// The result sits in an output register; a stalled receiver holds the block in
// its final state, and the next input is taken once that result is queued.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = 31,
    parameter int EXP_WIDTH = 31
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input transactions
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [BASE_WIDTH-1:0] i_base,
    input  wire logic [EXP_WIDTH-1:0]         i_exponent,
    // result transactions
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [MOD_WIDTH-1:0]              o_power,
    // modulus write
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [MOD_WIDTH-1:0]         i_cfg_modulus
);

    logic [MOD_WIDTH-1:0] r_modulus;
    logic                 r_out_valid;
    logic [MOD_WIDTH-1:0] r_power;

    t_dp_cmd              cmd;
    t_dp_stat             stat;
    logic [MOD_WIDTH-1:0] result;
    logic                 out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_WIDTH'(MODULUS_RESET);
        end else if (i_cfg_valid) begin
            r_modulus <= i_cfg_modulus;
        end
    end

    // output register slot is free now or frees at this edge
    assign out_free = !r_out_valid || i_out_ready;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    mexp_datapath #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_modulus  (r_modulus),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .o_stat     (stat),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_power <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_power     = r_power;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while pending");

    // results are canonical residues
    a_canonical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_modulus != '0)) |-> (o_power < r_modulus))
        else $error("result not below modulus");

    // a new input is never taken in the cycle a result is queued
    a_accept_vs_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !cmd.out_load)
        else $error("input accepted while a result is being queued");

    // accepting an input with a nonzero modulus starts the base reduction
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (r_modulus != '0)) |=> !o_in_ready)
        else $error("controller did not start after accept");

endmodule

`default_nettype wire
